// ----- rtl/core/rmwq_pkg.sv -----
// Shared types, constants and codes for the recursive lock with wait queue.
package rmwq_pkg;

  localparam int MAX_WAITERS    = 16;
  localparam int THREAD_ID_BITS = 8;

  localparam int ID_COUNT     = 1 << THREAD_ID_BITS;
  localparam int WQ_IDX_BITS  = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int WQ_CNT_BITS  = $clog2(MAX_WAITERS + 1);
  localparam int FIELD_ID_BITS = 8;
  localparam int DEPTH_BITS   = 8;
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef logic [THREAD_ID_BITS-1:0] tid_t;

  typedef enum logic [2:0] {
    ST_GRANTED    = 3'd0,
    ST_NESTED     = 3'd1,
    ST_BLOCKED    = 3'd2,
    ST_RELEASED   = 3'd3,
    ST_UNNESTED   = 3'd4,
    ST_NOT_HOLDER = 3'd5,
    ST_QUEUE_ERR  = 3'd6,
    ST_NEST_OVF   = 3'd7
  } status_t;

  // Wait queue lookups for the current requester
  typedef struct packed {
    logic waiting;
    logic full;
    logic empty;
    tid_t head_id;
  } wq_stat_t;

  // Queue updates decided by the lock logic
  typedef struct packed {
    logic push;
    logic pop;
  } wq_ctl_t;

  typedef struct packed {
    status_t                  status;
    logic                     woken_valid;
    logic [FIELD_ID_BITS-1:0] woken_thread;
    logic                     holder_valid;
    logic [FIELD_ID_BITS-1:0] holder_thread;
    logic [DEPTH_BITS-1:0]    nesting_count;
  } lock_res_t;

endpackage

// ----- rtl/core/rmwq_waitq.sv -----
// FIFO of blocked thread ids with a per-thread waiting map.
module rmwq_waitq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  rmwq_pkg::tid_t       req_id,
  input  rmwq_pkg::wq_ctl_t    ctl,
  output rmwq_pkg::wq_stat_t   stat
);

  localparam logic [rmwq_pkg::WQ_IDX_BITS-1:0] LAST_SLOT =
    rmwq_pkg::WQ_IDX_BITS'(rmwq_pkg::MAX_WAITERS - 1);
  localparam logic [rmwq_pkg::WQ_CNT_BITS-1:0] FULL_COUNT =
    rmwq_pkg::WQ_CNT_BITS'(rmwq_pkg::MAX_WAITERS);

  rmwq_pkg::tid_t                   slot_r [rmwq_pkg::MAX_WAITERS];
  logic [rmwq_pkg::WQ_IDX_BITS-1:0] head_r, head_nxt;
  logic [rmwq_pkg::WQ_IDX_BITS-1:0] tail_r, tail_nxt;
  logic [rmwq_pkg::WQ_CNT_BITS-1:0] count_r, count_nxt;
  logic [rmwq_pkg::ID_COUNT-1:0]    map_r, map_nxt;

  logic do_push, do_pop;

  assign do_push = fire && ctl.push;
  assign do_pop  = fire && ctl.pop;

  assign stat.waiting = map_r[req_id];
  assign stat.full    = (count_r == FULL_COUNT);
  assign stat.empty   = (count_r == '0);
  assign stat.head_id = slot_r[head_r];

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    map_nxt   = map_r;
    if (do_push) begin
      tail_nxt        = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
      count_nxt       = count_r + 1'b1;
      map_nxt[req_id] = 1'b1;
    end
    if (do_pop) begin
      head_nxt              = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
      count_nxt             = count_r - 1'b1;
      map_nxt[stat.head_id] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      map_r   <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      map_r   <= map_nxt;
    end
  end

  // slots hold no reset; only written slots are ever popped
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[tail_r] <= req_id;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("wait queue count beyond capacity");

  a_push_legal: assert property (@(posedge clk) disable iff (!rst_n)
    do_push |-> !stat.full && !stat.waiting)
    else $error("push into full queue or duplicate waiter");

  a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> !map_r[$past(stat.head_id)] && count_r == $past(count_r) - 1'b1)
    else $error("popped waiter still marked or count not lowered");

endmodule

// ----- rtl/core/rmwq_lock.sv -----
// Owner, nesting depth and semaphore state with the acquire/release decision.
module rmwq_lock (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic                 opcode,
  input  rmwq_pkg::tid_t       req_id,
  input  rmwq_pkg::wq_stat_t   wq,
  output rmwq_pkg::wq_ctl_t    ctl,
  output rmwq_pkg::lock_res_t  res
);

  logic                              sem_r, sem_nxt;
  logic                              own_v_r, own_v_nxt;
  rmwq_pkg::tid_t                    own_id_r, own_id_nxt;
  logic [rmwq_pkg::DEPTH_BITS-1:0]   depth_r, depth_nxt;

  logic             is_owner;
  rmwq_pkg::status_t status;

  assign is_owner = own_v_r && (own_id_r == req_id);

  always_comb begin
    sem_nxt    = sem_r;
    own_v_nxt  = own_v_r;
    own_id_nxt = own_id_r;
    depth_nxt  = depth_r;
    ctl.push   = 1'b0;
    ctl.pop    = 1'b0;
    if (opcode == rmwq_pkg::OP_ACQUIRE) begin
      if (is_owner) begin
        if (depth_r == rmwq_pkg::DEPTH_MAX) begin
          status = rmwq_pkg::ST_NEST_OVF;
        end else begin
          depth_nxt = depth_r + 1'b1;
          status    = rmwq_pkg::ST_NESTED;
        end
      end else if (sem_r) begin
        sem_nxt    = 1'b0;
        own_v_nxt  = 1'b1;
        own_id_nxt = req_id;
        depth_nxt  = rmwq_pkg::DEPTH_BITS'(1);
        status     = rmwq_pkg::ST_GRANTED;
      end else if (wq.waiting || wq.full) begin
        status = rmwq_pkg::ST_QUEUE_ERR;
      end else begin
        ctl.push = 1'b1;
        status   = rmwq_pkg::ST_BLOCKED;
      end
    end else begin
      if (!is_owner) begin
        status = rmwq_pkg::ST_NOT_HOLDER;
      end else if (depth_r > rmwq_pkg::DEPTH_BITS'(1)) begin
        depth_nxt = depth_r - 1'b1;
        status    = rmwq_pkg::ST_UNNESTED;
      end else begin
        own_v_nxt  = 1'b0;
        own_id_nxt = '0;
        depth_nxt  = '0;
        sem_nxt    = 1'b1;
        ctl.pop    = !wq.empty;
        status     = rmwq_pkg::ST_RELEASED;
      end
    end
  end

  always_comb begin
    res.status        = status;
    res.woken_valid   = ctl.pop;
    res.woken_thread  = ctl.pop ? rmwq_pkg::FIELD_ID_BITS'(wq.head_id) : '0;
    res.holder_valid  = own_v_nxt;
    res.holder_thread = own_v_nxt ? rmwq_pkg::FIELD_ID_BITS'(own_id_nxt) : '0;
    res.nesting_count = own_v_nxt ? depth_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sem_r    <= 1'b1;
      own_v_r  <= 1'b0;
      own_id_r <= '0;
      depth_r  <= '0;
    end else if (fire) begin
      sem_r    <= sem_nxt;
      own_v_r  <= own_v_nxt;
      own_id_r <= own_id_nxt;
      depth_r  <= depth_nxt;
    end
  end

  a_sem_matches_owner: assert property (@(posedge clk) disable iff (!rst_n)
    sem_r == !own_v_r)
    else $error("semaphore and owner flag disagree");

  a_owner_depth: assert property (@(posedge clk) disable iff (!rst_n)
    own_v_r |-> depth_r != '0)
    else $error("lock held at zero depth");

  a_free_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !own_v_r |-> depth_r == '0 && own_id_r == '0)
    else $error("free lock keeps owner id or depth");

endmodule

// ----- rtl/core/recursive_mutex_with_wait_queue_core.sv -----
// Top level of the recursive lock with a FIFO of waiting threads.
//
// Input channel (in_*): one word per request. in_tuser carries the opcode
// (0 acquire, 1 release), in_tdata the requesting thread id.
// Output channel (out_*): exactly one result word per request, in order,
// carrying the status, the woken waiter and the owner state after the request.
//
// A request sits in an input register, is decided against the lock and
// queue state there, and lands in the output register, from which the
// result word is offered. One request per cycle is sustained while the
// receiver takes result words; the decision and all state updates occur together.
//
// Reset (rst_n low, synchronous) frees the lock, empties the queue and
// clears every waiting flag. When the receiver stalls, the output word holds
// and the input register still takes one more word; tready drops once both
// registers are full, and nothing is lost.
module recursive_mutex_with_wait_queue_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] requester_thread
  input  logic        in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] status, [3] woken_valid, [11:4] woken_thread, [12] holder_valid,
  // [20:13] holder_thread, [28:21] nesting_count, [31:29] zero
  output logic [31:0] out_tdata
);

  logic                in_v_r;
  logic                in_op_r;
  logic [7:0]          in_req_r;
  logic                out_v_r;
  rmwq_pkg::lock_res_t out_res_r;

  logic                advance;
  logic                in_fire;
  rmwq_pkg::tid_t      req_id;
  rmwq_pkg::wq_stat_t  wq_stat;
  rmwq_pkg::wq_ctl_t   wq_ctl;
  rmwq_pkg::lock_res_t res;

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;
  assign in_fire   = in_tvalid && in_tready;
  assign req_id    = rmwq_pkg::THREAD_ID_BITS'(in_req_r);

  rmwq_lock u_lock (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .opcode (in_op_r),
    .req_id (req_id),
    .wq     (wq_stat),
    .ctl    (wq_ctl),
    .res    (res)
  );

  rmwq_waitq u_waitq (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .req_id (req_id),
    .ctl    (wq_ctl),
    .stat   (wq_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_fire) begin
        in_v_r <= 1'b1;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers: hold the word until its slot moves on
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_op_r  <= in_tuser;
      in_req_r <= in_tdata;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000,
                       out_res_r.nesting_count,
                       out_res_r.holder_thread,
                       out_res_r.holder_valid,
                       out_res_r.woken_thread,
                       out_res_r.woken_valid,
                       out_res_r.status};

endmodule

// ----- dv/tb_recursive_mutex_with_wait_queue_core.sv -----
// Self-checking testbench for the recursive lock with its FIFO of waiting threads.
module tb_recursive_mutex_with_wait_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 250000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  recursive_mutex_with_wait_queue_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Shadow of the lock state, advanced once per accepted request
  logic                            lock_free = 1'b1;
  logic                            own_valid = 1'b0;
  rmwq_pkg::tid_t                  own_id = '0;
  logic [rmwq_pkg::DEPTH_BITS-1:0] own_depth = '0;
  rmwq_pkg::tid_t                  wait_line[$];
  logic [rmwq_pkg::ID_COUNT-1:0]   queued_flag = '0;

  rmwq_pkg::lock_res_t pending_results[$];
  rmwq_pkg::tid_t      retry_ids[$];

  logic idle_en = 1'b1;
  int   hold_req = 0;
  int   hold_left = 0;
  int   stall_left = 0;
  int   sent = 0;
  int   checked = 0;
  int   errors = 0;
  int   status_seen[8] = '{default: 0};
  int unsigned cycles = 0;

  function automatic int pick_gap();
    if (idle_en) return $urandom_range(0, 10);
    return 0;
  endfunction

  function automatic rmwq_pkg::lock_res_t predict_lock(logic op, rmwq_pkg::tid_t tid);
    rmwq_pkg::lock_res_t r;
    logic                is_holder;
    r = '0;
    is_holder = own_valid && own_id == tid;
    if (op == rmwq_pkg::OP_ACQUIRE) begin
      if (is_holder) begin
        if (own_depth == rmwq_pkg::DEPTH_MAX) begin
          r.status = rmwq_pkg::ST_NEST_OVF;
        end else begin
          own_depth++;
          r.status = rmwq_pkg::ST_NESTED;
        end
      end else if (lock_free) begin
        lock_free = 1'b0;
        own_valid = 1'b1;
        own_id = tid;
        own_depth = rmwq_pkg::DEPTH_BITS'(1);
        r.status = rmwq_pkg::ST_GRANTED;
      end else if (queued_flag[tid] || wait_line.size() >= rmwq_pkg::MAX_WAITERS) begin
        r.status = rmwq_pkg::ST_QUEUE_ERR;
      end else begin
        wait_line.push_back(tid);
        queued_flag[tid] = 1'b1;
        r.status = rmwq_pkg::ST_BLOCKED;
      end
    end else begin
      if (!is_holder) begin
        r.status = rmwq_pkg::ST_NOT_HOLDER;
      end else if (own_depth > 1) begin
        own_depth--;
        r.status = rmwq_pkg::ST_UNNESTED;
      end else begin
        own_valid = 1'b0;
        own_id = '0;
        own_depth = '0;
        // pop the oldest waiter, it has to retry its acquire
        if (wait_line.size() > 0) begin
          r.woken_thread = wait_line.pop_front();
          r.woken_valid = 1'b1;
          queued_flag[r.woken_thread] = 1'b0;
        end
        lock_free = 1'b1;
        r.status = rmwq_pkg::ST_RELEASED;
      end
    end
    r.holder_valid = own_valid;
    r.holder_thread = own_valid ? own_id : '0;
    r.nesting_count = own_valid ? own_depth : '0;
    return r;
  endfunction

  task automatic send_request(input logic op, input rmwq_pkg::tid_t tid);
    int                  gap;
    rmwq_pkg::lock_res_t r;
    gap = pick_gap();
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= tid;
    do @(posedge clk); while (!in_tready);
    r = predict_lock(op, tid);
    pending_results.push_back(r);
    if (r.woken_valid) retry_ids.push_back(r.woken_thread);
    sent++;
  endtask

  // Receiver: random stall after each word, plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= (stall_left == 0);
    end else if (out_tvalid && out_tready) begin
      stall_left = pick_gap();
      out_tready <= (stall_left == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      if (errors < 40)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    rmwq_pkg::lock_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result word with no request pending, actual %h", $time, out_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_tdata[2:0]));
        check_field("woken_valid", 32'(want.woken_valid), 32'(out_tdata[3]));
        check_field("woken_thread", 32'(want.woken_thread), 32'(out_tdata[11:4]));
        check_field("holder_valid", 32'(want.holder_valid), 32'(out_tdata[12]));
        check_field("holder_thread", 32'(want.holder_thread), 32'(out_tdata[20:13]));
        check_field("nesting_count", 32'(want.nesting_count), 32'(out_tdata[28:21]));
        check_field("pad", 32'd0, 32'(out_tdata[31:29]));
        status_seen[want.status]++;
        checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
      $display("tb_recursive_mutex_with_wait_queue_core: FAIL");
      $finish;
    end
  end

  task automatic do_reset();
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // Walk every status but nesting overflow, and the stale-queue-entry cases, by hand
  task automatic test_directed();
    send_request(rmwq_pkg::OP_RELEASE, 8'h00);
    send_request(rmwq_pkg::OP_ACQUIRE, 8'h00);
    send_request(rmwq_pkg::OP_ACQUIRE, 8'h00);
    send_request(rmwq_pkg::OP_RELEASE, 8'hFF);
    send_request(rmwq_pkg::OP_ACQUIRE, 8'hFF);
    send_request(rmwq_pkg::OP_ACQUIRE, 8'hFF);
    send_request(rmwq_pkg::OP_ACQUIRE, 8'h80);
    send_request(rmwq_pkg::OP_RELEASE, 8'h00);
    send_request(rmwq_pkg::OP_RELEASE, 8'h00);
    // 0x80 grabs the free lock while still queued
    send_request(rmwq_pkg::OP_ACQUIRE, 8'h80);
    send_request(rmwq_pkg::OP_ACQUIRE, 8'hFF);
    send_request(rmwq_pkg::OP_RELEASE, 8'h80);
    send_request(rmwq_pkg::OP_ACQUIRE, 8'h80);
    send_request(rmwq_pkg::OP_RELEASE, 8'h80);
    send_request(rmwq_pkg::OP_RELEASE, 8'h80);
    send_request(rmwq_pkg::OP_ACQUIRE, 8'h7F);
    send_request(rmwq_pkg::OP_RELEASE, 8'h7F);
    send_request(rmwq_pkg::OP_ACQUIRE, 8'hFF);
    send_request(rmwq_pkg::OP_RELEASE, 8'hFF);
    retry_ids.delete();
  endtask

  // Drive one owner to the depth limit and back down
  task automatic test_nest_overflow();
    idle_en = 1'b0;
    for (int i = 0; i < 257; i++) send_request(rmwq_pkg::OP_ACQUIRE, 8'h5A);
    send_request(rmwq_pkg::OP_ACQUIRE, 8'hA5);
    for (int i = 0; i < 255; i++) send_request(rmwq_pkg::OP_RELEASE, 8'h5A);
    send_request(rmwq_pkg::OP_ACQUIRE, 8'hA5);
    send_request(rmwq_pkg::OP_RELEASE, 8'hA5);
    idle_en = 1'b1;
    retry_ids.delete();
  endtask

  // Fill the wait queue, overflow it, then hand the lock down the line
  task automatic test_queue_full();
    rmwq_pkg::tid_t holder;
    holder = 8'h11;
    send_request(rmwq_pkg::OP_ACQUIRE, holder);
    for (int i = 0; i < rmwq_pkg::MAX_WAITERS; i++)
      send_request(rmwq_pkg::OP_ACQUIRE, rmwq_pkg::tid_t'(8'hE0 + i));
    send_request(rmwq_pkg::OP_ACQUIRE, 8'h3C);
    send_request(rmwq_pkg::OP_ACQUIRE, 8'hE3);
    for (int i = 0; i < rmwq_pkg::MAX_WAITERS; i++) begin
      send_request(rmwq_pkg::OP_RELEASE, holder);
      holder = rmwq_pkg::tid_t'(8'hE0 + i);
      send_request(rmwq_pkg::OP_ACQUIRE, holder);
    end
    send_request(rmwq_pkg::OP_RELEASE, holder);
    retry_ids.delete();
  endtask

  // Stall the receiver long enough that the input backs up
  task automatic test_pressure();
    idle_en = 1'b0;
    hold_req = 80;
    for (int i = 0; i < 30; i++)
      send_request(logic'(i % 3 == 2), rmwq_pkg::tid_t'($urandom_range(0, 3)));
    idle_en = 1'b1;
  endtask

  task automatic test_random(input int count);
    rmwq_pkg::tid_t crew[$];
    int             pick;
    for (int i = 0; i < count; i++) begin
      if (i % 80 == 0) begin
        crew.delete();
        repeat ($urandom_range(2, 24))
          crew.push_back(rmwq_pkg::tid_t'($urandom_range(0, 255)));
      end
      if (i % 64 == 0) idle_en = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (retry_ids.size() > 0 && pick < 25)
        send_request(rmwq_pkg::OP_ACQUIRE, retry_ids.pop_front());
      else if (own_valid && pick < 55)
        send_request(logic'($urandom_range(0, 1)), own_id);
      else if (pick < 88)
        send_request(rmwq_pkg::OP_ACQUIRE, crew[$urandom_range(0, crew.size() - 1)]);
      else if (pick < 94)
        send_request(rmwq_pkg::OP_RELEASE, crew[$urandom_range(0, crew.size() - 1)]);
      else
        send_request(logic'($urandom_range(0, 1)), rmwq_pkg::tid_t'($urandom_range(0, 255)));
    end
    idle_en = 1'b1;
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    do_reset();
    test_directed();
    test_nest_overflow();
    test_queue_full();
    test_pressure();
    test_random(560);
    wait_drain();
    $display("Ran %0d requests over %0d cycles, %0d result words checked", sent, cycles,
             checked);
    $display("Status mix granted..overflow: %0d %0d %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
    if (errors == 0) begin
      $display("tb_recursive_mutex_with_wait_queue_core: PASS");
    end else begin
      $display("tb_recursive_mutex_with_wait_queue_core: FAIL");
    end
    $finish;
  end

endmodule
